@@ rtl/agb_pkg.sv @@
`timescale 1ns / 1ps
package agb_pkg;

  localparam int unsigned GRID_CELLS_DEF = 16;
  localparam int unsigned CELL_DEPTH_DEF = 4;
  localparam logic [30:0] MIN_CELL_RST = 31'd1048576;
  localparam int unsigned DIV_W = 40;

  localparam logic [1:0] ACT_REG   = 2'd0;
  localparam logic [1:0] ACT_QUERY = 2'd1;
  localparam logic [1:0] ACT_EOF   = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [15:0] object_id;
  } item_t;

  typedef struct packed {
    logic [15:0] found_id;
    logic        hit_valid;
    logic [3:0]  cell_x;
    logic [3:0]  cell_y;
    logic        overflow;
    logic        last;
  } result_t;

  // saturate a 34-bit two's complement value to 32 bits
  function automatic logic [31:0] sat_edge(input logic [33:0] v);
    if (!v[33] && (v[32:31] != 2'b00)) begin
      sat_edge = 32'h7FFF_FFFF;
    end else if (v[33] && (v[32:31] != 2'b11)) begin
      sat_edge = 32'h8000_0000;
    end else begin
      sat_edge = v[31:0];
    end
  endfunction

  // -(grid * m) / 2, saturated; m of zero counts as one
  function automatic logic [31:0] init_edge(input logic [30:0] m, input logic [6:0] g);
    logic [30:0] mm;
    logic [37:0] ext;
    logic [36:0] half;
    mm   = (m == 31'd0) ? 31'd1 : m;
    ext  = 38'(mm) * 38'(g);
    half = ext[37:1];
    if (half > 37'h0_8000_0000) begin
      init_edge = 32'h8000_0000;
    end else begin
      init_edge = ~half[31:0] + 32'd1;
    end
  endfunction

  // neighbor walk: left, lower left, upper left, above, below, right,
  // lower right, upper right, own cell (2-bit two's complement offsets)
  function automatic logic [1:0] nb_dx(input logic [3:0] i);
    unique case (i)
      4'd0, 4'd1, 4'd2: nb_dx = 2'b11;
      4'd5, 4'd6, 4'd7: nb_dx = 2'b01;
      default:          nb_dx = 2'b00;
    endcase
  endfunction

  function automatic logic [1:0] nb_dy(input logic [3:0] i);
    unique case (i)
      4'd1, 4'd4, 4'd6: nb_dy = 2'b11;
      4'd2, 4'd3, 4'd7: nb_dy = 2'b01;
      default:          nb_dy = 2'b00;
    endcase
  endfunction

endpackage

@@ rtl/agb_ram.sv @@
`timescale 1ns / 1ps
module agb_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/agb_div.sv @@
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle
module agb_div import agb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [31:0]      divisor_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] dvd_q, dvd_d;
  logic [31:0]      rem_q, rem_d, dsr_q, dsr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [32:0]      rem_sh, rem_sub;

  always_comb begin
    rem_sh  = {rem_q, dvd_q[DIV_W-1]};
    rem_sub = rem_sh - {1'b0, dsr_q};
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    dsr_d   = dsr_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    if (start_i) begin
      dvd_d = dividend_i;
      rem_d = 32'd0;
      dsr_d = (divisor_i == 32'd0) ? 32'd1 : divisor_i;
      cnt_d = CNT_W'(DIV_W);
    end else if (cnt_q != '0) begin
      if (!rem_sub[32]) begin
        rem_d = rem_sub[31:0];
        dvd_d = {dvd_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[31:0];
        dvd_d = {dvd_q[DIV_W-2:0], 1'b0};
      end
      cnt_d  = cnt_q - CNT_W'(1);
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule

@@ rtl/agb_front.sv @@
`timescale 1ns / 1ps
// two-entry command queue; unknown actions are taken and dropped here
module agb_front import agb_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  item_t item_i,
  output logic  busy_o,
  output item_t head_o,
  output logic  head_valid_o,
  input  logic  pop_i
);

  item_t      slot_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       known, push;

  assign known  = (item_i.action == ACT_REG) || (item_i.action == ACT_QUERY) ||
                  (item_i.action == ACT_EOF);
  assign busy_o = (cnt_q == 2'd2);
  assign push   = start_i && !busy_o && known;

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= item_i;
    end
  end

  assign head_o       = slot_q[rd_q];
  assign head_valid_o = (cnt_q != 2'd0);

endmodule

@@ rtl/agb_back.sv @@
`timescale 1ns / 1ps
module agb_back import agb_pkg::*; #(
  parameter int unsigned GRID_CELLS = GRID_CELLS_DEF,
  parameter int unsigned CELL_DEPTH = CELL_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [30:0] cfg_wdata_i,
  input  item_t       head_i,
  input  logic        head_valid_i,
  output logic        pop_o,
  output result_t     result_o,
  output logic        result_valid_o
);

  localparam int unsigned CW     = $clog2(GRID_CELLS);
  localparam int unsigned FW     = $clog2(CELL_DEPTH + 1);
  localparam int unsigned SW     = (CELL_DEPTH > 1) ? $clog2(CELL_DEPTH) : 1;
  localparam int unsigned FA     = 2 * CW;
  localparam int unsigned FDEPTH = 1 << FA;
  localparam int unsigned SDEPTH = 1 << (FA + SW);
  localparam logic [6:0]  K7     = 7'(GRID_CELLS - 2);
  localparam logic [CW-1:0] CLAST = CW'(GRID_CELLS - 1);
  localparam logic [15:0] TRACK_MIN = 16'd20;
  // reciprocal of the inner cell count, exact for 31-bit dividends
  localparam int unsigned KD    = GRID_CELLS - 2;
  localparam int unsigned KL    = $clog2(KD);
  localparam int unsigned RSH   = 31 + KL;
  localparam logic [31:0] RECIP = 32'(((64'd1 << RSH) + 64'(KD) - 64'd1) / 64'(KD));

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_BIN   = 4'd2;
  localparam logic [3:0] S_RRD   = 4'd3;
  localparam logic [3:0] S_RWR   = 4'd4;
  localparam logic [3:0] S_QNB   = 4'd5;
  localparam logic [3:0] S_QFL   = 4'd6;
  localparam logic [3:0] S_QRD   = 4'd7;
  localparam logic [3:0] S_QEM   = 4'd8;
  localparam logic [3:0] S_QEND  = 4'd9;
  localparam logic [3:0] S_EINIT = 4'd10;
  localparam logic [3:0] S_ESTEP = 4'd11;
  localparam logic [3:0] S_EWAIT = 4'd12;
  localparam logic [3:0] S_EDONE = 4'd13;

  logic [3:0]       state_q, state_d;
  logic [30:0]      min_q, min_d;
  logic [31:0]      left_q, left_d, bottom_q, bottom_d;
  logic [31:0]      width_q, width_d, height_q, height_d;
  logic [15:0]      tracked_q, tracked_d;
  logic [3:0][15:0] bord_q, bord_d;
  logic [FA-1:0]    clr_q, clr_d;
  logic [1:0]       act_q, act_d;
  logic [15:0]      id_q, id_d;
  logic             negx_q, negx_d, negy_q, negy_d;
  logic [CW-1:0]    cx_q, cx_d, cy_q, cy_d;
  logic [3:0]       nb_q, nb_d;
  logic [FA-1:0]    ncell_q, ncell_d;
  logic [FW-1:0]    nfill_q, nfill_d, slot_q, slot_d;
  logic             pend_v_q, pend_v_d;
  logic [15:0]      pend_id_q, pend_id_d;
  logic [2:0]       step_q, step_d;
  logic [15:0]      tenth_q, tenth_d;
  logic [1:0]       shrink_q, shrink_d;
  logic [30:0]      rq_q, rq_d;
  result_t          res_q, res_d;
  logic             res_v_q, res_v_d;

  // memories
  logic             fill_we;
  logic [FA-1:0]    fill_waddr, fill_raddr;
  logic [FW-1:0]    fill_wdata, fill_rdata;
  logic             store_we;
  logic [15:0]      store_rdata;

  // dividers
  logic             div_start0, div_start1, div_done0, div_done1;
  logic [DIV_W-1:0] dvd0, dvd1, quot0, quot1;
  logic [31:0]      dsr0, dsr1;

  // datapath helpers
  logic [32:0]      dx, dy;
  logic [1:0]       ndx, ndy;
  logic [CW:0]      nxs, nys;
  logic             nb_in;
  logic [CW+3:0]    cxw, cyw;
  logic             ax, cond, ovf;
  logic [31:0]      sel_size, sel_edge, new_edge, new_size;
  logic [30:0]      half;
  logic [62:0]      rprod;
  logic [37:0]      qk;
  logic             rup;
  logic [32:0]      gsum;
  logic [15:0]      near_cnt, far_cnt;
  logic [32:0]      tprod;
  logic [CW-1:0]    bx, by;

  assign dx = {head_i.pos_x[31], head_i.pos_x} - {left_q[31], left_q};
  assign dy = {head_i.pos_y[31], head_i.pos_y} - {bottom_q[31], bottom_q};

  assign ndx   = nb_dx(nb_q);
  assign ndy   = nb_dy(nb_q);
  assign nxs   = {1'b0, cx_q} + {{(CW-1){ndx[1]}}, ndx};
  assign nys   = {1'b0, cy_q} + {{(CW-1){ndy[1]}}, ndy};
  assign nb_in = !nxs[CW] && !nys[CW] && (nxs[CW-1:0] <= CLAST) && (nys[CW-1:0] <= CLAST);

  assign cxw = {4'b0000, cx_q};
  assign cyw = {4'b0000, cy_q};

  // bin: below the edge goes to border 0, far out to the last border
  assign bx = negx_q ? '0 : ((quot0 >= DIV_W'(K7)) ? CLAST : quot0[CW-1:0] + CW'(1));
  assign by = negy_q ? '0 : ((quot1 >= DIV_W'(K7)) ? CLAST : quot1[CW-1:0] + CW'(1));

  // resize step: axis in step bit 2, rule in bits 1:0
  assign ax       = step_q[2];
  assign sel_size = ax ? height_q : width_q;
  assign sel_edge = ax ? bottom_q : left_q;
  assign near_cnt = ax ? bord_q[2] : bord_q[0];
  assign far_cnt  = ax ? bord_q[3] : bord_q[1];
  assign half     = sel_size[31:1];
  assign new_edge = step_q[1] ? sat_edge({{2{sel_edge[31]}}, sel_edge} - {3'b000, half})
                              : sat_edge({{2{sel_edge[31]}}, sel_edge} + {3'b000, half});
  // (size*k +- half)/k = size + half/k on grow, size - ceil(half/k) on shrink
  assign rprod    = 63'(half) * 63'(RECIP);
  assign qk       = 38'(rq_q) * 38'(KD);
  assign rup      = (qk != 38'(half));
  assign gsum     = {1'b0, sel_size} + {2'b00, rq_q};
  assign new_size = step_q[1] ? (gsum[32] ? 32'hFFFF_FFFF : gsum[31:0])
                              : (sel_size - {1'b0, rq_q} - {31'd0, rup});
  assign tprod    = 33'(tracked_q) * 33'h0_CCCD;

  always_comb begin
    unique case (step_q[1:0])
      2'd0:    cond = shrink_q[ax] && (near_cnt == 16'd0);
      2'd1:    cond = shrink_q[ax] && (far_cnt == 16'd0);
      2'd2:    cond = near_cnt > tenth_q;
      default: cond = far_cnt > tenth_q;
    endcase
  end

  assign pop_o      = (state_q == S_IDLE) && head_valid_i;
  assign div_start0 = pop_o && (head_i.action != ACT_EOF);
  assign div_start1 = pop_o && (head_i.action != ACT_EOF);
  assign dvd0       = {7'd0, dx};
  assign dsr0       = width_q;
  assign dvd1       = {7'd0, dy};
  assign dsr1       = height_q;

  assign fill_raddr = (state_q == S_RRD) ? {cx_q, cy_q} : {nxs[CW-1:0], nys[CW-1:0]};
  assign ovf        = (fill_rdata >= FW'(CELL_DEPTH));
  assign fill_we    = (state_q == S_CLR) || ((state_q == S_RWR) && !ovf);
  assign fill_waddr = (state_q == S_CLR) ? clr_q : {cx_q, cy_q};
  assign fill_wdata = (state_q == S_CLR) ? '0 : fill_rdata + FW'(1);
  assign store_we   = (state_q == S_RWR) && !ovf;

  always_comb begin
    state_d   = state_q;
    min_d     = min_q;
    left_d    = left_q;
    bottom_d  = bottom_q;
    width_d   = width_q;
    height_d  = height_q;
    tracked_d = tracked_q;
    bord_d    = bord_q;
    clr_d     = clr_q;
    act_d     = act_q;
    id_d      = id_q;
    negx_d    = negx_q;
    negy_d    = negy_q;
    cx_d      = cx_q;
    cy_d      = cy_q;
    nb_d      = nb_q;
    ncell_d   = ncell_q;
    nfill_d   = nfill_q;
    slot_d    = slot_q;
    pend_v_d  = pend_v_q;
    pend_id_d = pend_id_q;
    step_d    = step_q;
    tenth_d   = tenth_q;
    shrink_d  = shrink_q;
    rq_d      = rq_q;
    res_d     = res_q;
    res_v_d   = 1'b0;

    unique case (state_q)
      S_CLR: begin
        clr_d = clr_q + FA'(1);
        if (clr_q == FA'(FDEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (head_valid_i) begin
          act_d   = head_i.action;
          id_d    = head_i.object_id;
          negx_d  = dx[32];
          negy_d  = dy[32];
          state_d = (head_i.action == ACT_EOF) ? S_EINIT : S_BIN;
        end
      end
      S_BIN: begin
        if (div_done0 && div_done1) begin
          cx_d     = bx;
          cy_d     = by;
          nb_d     = 4'd0;
          pend_v_d = 1'b0;
          state_d  = (act_q == ACT_REG) ? S_RRD : S_QNB;
        end
      end
      S_RRD: begin
        state_d = S_RWR;
      end
      S_RWR: begin
        tracked_d = (tracked_q == 16'hFFFF) ? tracked_q : tracked_q + 16'd1;
        if ((cx_q == '0) && (bord_q[0] != 16'hFFFF)) bord_d[0] = bord_q[0] + 16'd1;
        if ((cx_q == CLAST) && (bord_q[1] != 16'hFFFF)) bord_d[1] = bord_q[1] + 16'd1;
        if ((cy_q == '0) && (bord_q[2] != 16'hFFFF)) bord_d[2] = bord_q[2] + 16'd1;
        if ((cy_q == CLAST) && (bord_q[3] != 16'hFFFF)) bord_d[3] = bord_q[3] + 16'd1;
        res_d   = '{found_id: 16'd0, hit_valid: 1'b0, cell_x: cxw[3:0], cell_y: cyw[3:0],
                    overflow: ovf, last: 1'b1};
        res_v_d = 1'b1;
        state_d = S_IDLE;
      end
      S_QNB: begin
        if (nb_in) begin
          ncell_d = {nxs[CW-1:0], nys[CW-1:0]};
          state_d = S_QFL;
        end else if (nb_q == 4'd8) begin
          state_d = S_QEND;
        end else begin
          nb_d = nb_q + 4'd1;
        end
      end
      S_QFL: begin
        nfill_d = fill_rdata;
        slot_d  = '0;
        if (fill_rdata != '0) begin
          state_d = S_QRD;
        end else if (nb_q == 4'd8) begin
          state_d = S_QEND;
        end else begin
          nb_d    = nb_q + 4'd1;
          state_d = S_QNB;
        end
      end
      S_QRD: begin
        state_d = S_QEM;
      end
      S_QEM: begin
        // hold one hit back so the final one can carry last
        if (pend_v_q) begin
          res_d   = '{found_id: pend_id_q, hit_valid: 1'b1, cell_x: cxw[3:0],
                      cell_y: cyw[3:0], overflow: 1'b0, last: 1'b0};
          res_v_d = 1'b1;
        end
        pend_v_d  = 1'b1;
        pend_id_d = store_rdata;
        slot_d    = slot_q + FW'(1);
        if ((slot_q + FW'(1)) < nfill_q) begin
          state_d = S_QRD;
        end else if (nb_q == 4'd8) begin
          state_d = S_QEND;
        end else begin
          nb_d    = nb_q + 4'd1;
          state_d = S_QNB;
        end
      end
      S_QEND: begin
        res_d   = '{found_id: pend_v_q ? pend_id_q : 16'd0, hit_valid: pend_v_q,
                    cell_x: cxw[3:0], cell_y: cyw[3:0], overflow: 1'b0, last: 1'b1};
        res_v_d = 1'b1;
        state_d = S_IDLE;
      end
      S_EINIT: begin
        tenth_d     = {3'b000, tprod[31:19]};
        shrink_d[0] = width_q > {1'b0, min_q};
        shrink_d[1] = height_q > {1'b0, min_q};
        step_d      = 3'd0;
        state_d     = (tracked_q > TRACK_MIN) ? S_ESTEP : S_EDONE;
      end
      S_ESTEP: begin
        if (cond) begin
          if (!step_q[0]) begin
            if (ax) bottom_d = new_edge;
            else    left_d   = new_edge;
          end
          rq_d    = 31'(rprod >> RSH);
          state_d = S_EWAIT;
        end else if (step_q == 3'd7) begin
          state_d = S_EDONE;
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      S_EWAIT: begin
        if (ax) height_d = new_size;
        else    width_d  = new_size;
        if (step_q == 3'd7) begin
          state_d = S_EDONE;
        end else begin
          step_d  = step_q + 3'd1;
          state_d = S_ESTEP;
        end
      end
      S_EDONE: begin
        res_d     = '{found_id: 16'd0, hit_valid: 1'b0, cell_x: 4'd0, cell_y: 4'd0,
                      overflow: 1'b0, last: 1'b1};
        res_v_d   = 1'b1;
        tracked_d = 16'd0;
        bord_d    = '0;
        clr_d     = '0;
        state_d   = S_CLR;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      min_d    = cfg_wdata_i;
      left_d   = init_edge(cfg_wdata_i, 7'(GRID_CELLS));
      bottom_d = init_edge(cfg_wdata_i, 7'(GRID_CELLS));
      width_d  = (cfg_wdata_i == 31'd0) ? 32'd1 : {1'b0, cfg_wdata_i};
      height_d = (cfg_wdata_i == 31'd0) ? 32'd1 : {1'b0, cfg_wdata_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      clr_q     <= '0;
      min_q     <= MIN_CELL_RST;
      left_q    <= init_edge(MIN_CELL_RST, 7'(GRID_CELLS));
      bottom_q  <= init_edge(MIN_CELL_RST, 7'(GRID_CELLS));
      width_q   <= {1'b0, MIN_CELL_RST};
      height_q  <= {1'b0, MIN_CELL_RST};
      tracked_q <= 16'd0;
      bord_q    <= '0;
      pend_v_q  <= 1'b0;
      res_v_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      min_q     <= min_d;
      left_q    <= left_d;
      bottom_q  <= bottom_d;
      width_q   <= width_d;
      height_q  <= height_d;
      tracked_q <= tracked_d;
      bord_q    <= bord_d;
      pend_v_q  <= pend_v_d;
      res_v_q   <= res_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q     <= act_d;
    id_q      <= id_d;
    negx_q    <= negx_d;
    negy_q    <= negy_d;
    cx_q      <= cx_d;
    cy_q      <= cy_d;
    nb_q      <= nb_d;
    ncell_q   <= ncell_d;
    nfill_q   <= nfill_d;
    slot_q    <= slot_d;
    pend_id_q <= pend_id_d;
    step_q    <= step_d;
    tenth_q   <= tenth_d;
    shrink_q  <= shrink_d;
    rq_q      <= rq_d;
    res_q     <= res_d;
  end

  agb_div u_div_x (
    .clk_i, .rst_ni, .start_i(div_start0), .dividend_i(dvd0), .divisor_i(dsr0),
    .done_o(div_done0), .quot_o(quot0)
  );

  agb_div u_div_y (
    .clk_i, .rst_ni, .start_i(div_start1), .dividend_i(dvd1), .divisor_i(dsr1),
    .done_o(div_done1), .quot_o(quot1)
  );

  agb_ram #(.WIDTH(FW), .DEPTH(FDEPTH)) u_fill (
    .clk_i, .we_i(fill_we), .waddr_i(fill_waddr), .wdata_i(fill_wdata),
    .raddr_i(fill_raddr), .rdata_o(fill_rdata)
  );

  agb_ram #(.WIDTH(16), .DEPTH(SDEPTH)) u_store (
    .clk_i, .we_i(store_we), .waddr_i({cx_q, cy_q, fill_rdata[SW-1:0]}), .wdata_i(id_q),
    .raddr_i({ncell_q, slot_q[SW-1:0]}), .rdata_o(store_rdata)
  );

  assign result_o       = res_q;
  assign result_valid_o = res_v_q;

endmodule

@@ rtl/adaptive_grid_broadphase_top.sv @@
`timescale 1ns / 1ps
// Uniform-grid broad phase with adaptive bounds. A command is taken on a clock
// edge with start_i high and busy_o low; results come out one beat per strobe
// on result_valid_o and cannot be held off, so the receiver must take each beat
// in the cycle it appears. Binning runs two 40-step serial dividers (x and y
// side by side) for register and query commands; a query then visits each
// neighbor cell on the grid, skips neighbors off the grid and reads each id
// that a visited cell holds from the cell store. End of frame takes up to 8
// resize steps, and a step that applies also writes the new size (the divide
// by the inner cell count is a reciprocal multiply), then a clearing pass over
// all 2^(2*clog2(GRID_CELLS)) fill counts (256 at the default size); the same
// clearing pass runs once after reset before the first command is executed. A
// two-entry command queue lets up to two commands be taken while one is in
// progress.
module adaptive_grid_broadphase_top import agb_pkg::*; #(
  parameter int unsigned GRID_CELLS = GRID_CELLS_DEF,
  parameter int unsigned CELL_DEPTH = CELL_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  item_t       item_i,
  output result_t     result_o,
  output logic        result_valid_o,
  input  logic        cfg_we_i,
  input  logic [30:0] cfg_wdata_i
);

  item_t head;
  logic  head_valid;
  logic  pop;

  // front: takes commands, drops unknown actions, queues the rest
  agb_front u_front (
    .clk_i, .rst_ni, .start_i, .item_i, .busy_o,
    .head_o(head), .head_valid_o(head_valid), .pop_i(pop)
  );

  // back: binning, cell store, neighbor walk, frame resize and clear
  agb_back #(.GRID_CELLS(GRID_CELLS), .CELL_DEPTH(CELL_DEPTH)) u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .head_i(head), .head_valid_i(head_valid), .pop_o(pop),
    .result_o, .result_valid_o
  );

endmodule

@@ rtl/agb_checker.sv @@
`timescale 1ns / 1ps
module agb_checker import agb_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input result_t     result_o,
  input logic        result_valid_o
);

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.hit_valid |-> result_o.found_id == 16'd0)
    else $error("miss beat carries an id");

  a_hit_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.hit_valid |-> !result_o.overflow)
    else $error("hit beat flags overflow");

  a_ovf_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.overflow |-> result_o.last)
    else $error("overflow beat not last");

endmodule

bind adaptive_grid_broadphase_top agb_checker u_agb_checker (.*);
